// File: rtl/tsam_pkg.sv
// Shared types, widths and the in-block swizzle function of the texel address map.
// No dependencies; every other file of the block imports this package.
package tsam_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned TexelW  = 8;
  localparam int unsigned OffsetW = 20;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned PAddrW  = 3;
  localparam int unsigned PDataW  = 32;

  // Largest texture side; an exponent above its log is clamped to it.
  localparam int unsigned MaxSide     = 1024;
  localparam int unsigned MaxSideLog2 = $clog2(MaxSide);

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH_LOG2  = 1'b0;
  localparam logic REG_HEIGHT_LOG2 = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_SMALL_H = 2'd2
  } status_e;

  typedef struct packed {
    logic [ExpW-1:0] width_log2;
    logic [ExpW-1:0] height_log2;
  } cfg_t;

  // Exponent of the effective side, clamped to the largest side.
  function automatic logic [ExpW-1:0] side_log2(input logic [ExpW-1:0] e);
    logic [ExpW-1:0] lim;
    lim = ExpW'(MaxSideLog2);
    return (e > lim) ? lim : e;
  endfunction

  // Inverse of the column table: the slot index of byte s within its column.
  // The even table maps slot bits {i5..i0} to byte bits
  // {i0, i5, i1, i4^i0, i3, i2}; the odd table is the even one with i4 flipped.
  function automatic logic [5:0] col_slot(input logic odd_col, input logic [5:0] s);
    logic [5:0] i;
    i[0] = s[5];
    i[1] = s[3];
    i[2] = s[0];
    i[3] = s[1];
    i[4] = s[2] ^ s[5] ^ odd_col;
    i[5] = s[4];
    return i;
  endfunction

endpackage

// File: rtl/tsam_in_if.sv
// Input channel of the texel address map: a valid/ready beat of coordinates and texel.
// Depends on tsam_pkg for the field widths.
interface tsam_in_if import tsam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] src_x;
  logic [CoordW-1:0] src_y;
  logic [TexelW-1:0] texel;

  modport source (output valid, src_x, src_y, texel, input ready);
  modport sink   (input valid, src_x, src_y, texel, output ready);
endinterface

// File: rtl/tsam_out_if.sv
// Result channel of the texel address map: a valid/ready beat of offset, texel and status.
// Depends on tsam_pkg for the field widths.
interface tsam_out_if import tsam_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OffsetW-1:0] dest_offset;
  logic [TexelW-1:0]  texel_out;
  logic [StatusW-1:0] status;

  modport source (output valid, dest_offset, texel_out, status, input ready);
  modport sink   (input valid, dest_offset, texel_out, status, output ready);
endinterface

// File: rtl/tsam_cfg.sv
// APB-style register file holding the width and height exponents.
// Depends on tsam_pkg for the register layout and cfg_t.
module tsam_cfg import tsam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_WIDTH_LOG2:  cfg_d.width_log2  = pwdata[ExpW-1:0];
        REG_HEIGHT_LOG2: cfg_d.height_log2 = pwdata[ExpW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH_LOG2:  prdata = PDataW'(cfg_q.width_log2);
      REG_HEIGHT_LOG2: prdata = PDataW'(cfg_q.height_log2);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_log2  <= ExpW'(7);
      cfg_q.height_log2 <= ExpW'(6);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tsam_addr.sv
// Combinational address map from one registered texel position to its swizzled offset.
// Depends on tsam_pkg for side_log2, col_slot, cfg_t and status_e.
module tsam_addr import tsam_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic [CoordW-1:0]  x_i,
  input  logic [CoordW-1:0]  y_i,
  output logic [OffsetW-1:0] offset_o,
  output status_e            status_o
);

  logic [ExpW-1:0]    wl, hl;
  logic [ExpW-1:0]    ph_l;
  logic [ExpW-1:0]    row_sh, pw_sh;
  logic [ExpW+1:0]    page_sh;
  logic               x_oob, y_oob, narrow, small_h;
  logic [5:0]         py;
  logic [6:0]         px;
  logic [5:0]         slot;
  logic [7:0]         opos;
  logic [4:0]         orow;
  logic [7:0]         ocol;
  logic [3:0]         pi;
  logic [2:0]         pj;
  logic [OffsetW-1:0] lin_off, swz_off;

  assign wl = side_log2(cfg_i.width_log2);
  assign hl = side_log2(cfg_i.height_log2);

  // Sides are powers of two, so the range check is a shift test.
  assign x_oob   = ((32'(x_i) >> wl) != 32'd0);
  assign y_oob   = ((32'(y_i) >> hl) != 32'd0);
  assign narrow  = (wl < ExpW'(4));
  assign small_h = (hl < ExpW'(2));

  assign py   = y_i[5:0];
  assign px   = x_i[6:0];
  // Byte index inside the 16x16 block is {py[3:0], px[3:0]}; its top two bits pick the column.
  assign slot = col_slot(py[2], {py[1:0], px[3:0]});
  assign opos = {py[3:2], slot};
  assign orow = {py[5:4], opos[7:5]};
  assign ocol = {px[6:4], opos[4:0]};
  assign pi   = y_i[CoordW-1:6];
  assign pj   = x_i[CoordW-1:7];

  // Page height is H/2 below 64 rows, else 32; page width is 2W below 128, else 256.
  assign ph_l    = (hl < ExpW'(6)) ? (hl - ExpW'(1)) : ExpW'(5);
  assign row_sh  = wl + ExpW'(1);
  assign pw_sh   = (wl < ExpW'(7)) ? row_sh : ExpW'(8);
  assign page_sh = (ExpW+2)'(ph_l) + (ExpW+2)'(row_sh);

  assign lin_off = (OffsetW'(y_i) << wl) + OffsetW'(x_i);
  assign swz_off = (OffsetW'(pi) << page_sh) + (OffsetW'(pj) << pw_sh)
                 + (OffsetW'(orow) << row_sh) + OffsetW'(ocol);

  always_comb begin
    if (x_oob || y_oob) begin
      status_o = STATUS_RANGE;
      offset_o = '0;
    end else if (narrow) begin
      status_o = STATUS_OK;
      offset_o = lin_off;
    end else if (small_h) begin
      status_o = STATUS_SMALL_H;
      offset_o = '0;
    end else begin
      status_o = STATUS_OK;
      offset_o = swz_off;
    end
  end

endmodule

// File: rtl/texel8_swizzle_address_map.sv
// Top level of the 8-bit texel swizzle address map: input register, address logic, result register.
// Depends on tsam_pkg, tsam_in_if, tsam_out_if, tsam_cfg and tsam_addr.
//
//   Port      Dir  Kind        Carries
//   in_i      in   valid/ready src_x, src_y, texel
//   out_o     out  valid/ready dest_offset, texel_out, status
//   APB       in   write/read  width_log2 (0x0), height_log2 (0x4)
//
// An accepted beat is held in the input register, then passes through the address logic into
// the result register. One beat is accepted every cycle unless both registers are full and the result is not taken.
// Reset clears both stage valids and loads width_log2 = 7, height_log2 = 6.
// When the result is not taken, the stages fill and in_i.ready drops once both registers hold a beat.
module texel8_swizzle_address_map import tsam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsam_in_if.sink           in_i,
  tsam_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  logic               in_valid_q;
  logic [CoordW-1:0]  x_q, y_q;
  logic [TexelW-1:0]  tex_q;
  logic               out_valid_q;
  logic [OffsetW-1:0] off_q;
  logic [TexelW-1:0]  tex_out_q;
  status_e            status_q;
  logic [OffsetW-1:0] off_d;
  status_e            status_d;
  logic               out_ready, in_ready, in_fire, out_load;

  tsam_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsam_addr u_addr (
    .cfg_i    (cfg),
    .x_i      (x_q),
    .y_i      (y_q),
    .offset_o (off_d),
    .status_o (status_d)
  );

  assign out_ready = !out_valid_q || out_o.ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_fire   = in_i.valid && in_ready;
  assign out_load  = in_valid_q && out_ready;

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= in_i.src_x;
      y_q   <= in_i.src_y;
      tex_q <= in_i.texel;
    end
    if (out_load) begin
      off_q     <= off_d;
      tex_out_q <= tex_q;
      status_q  <= status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dest_offset = off_q;
  assign out_o.texel_out   = tex_out_q;
  assign out_o.status      = status_q;

endmodule
